@@ rtl/lbce_pkg.sv @@
// ----------------------------------------------------------------------------
// lbce_pkg
// Shared constants, payload structs and command codes for the label bitset
// combine and extract block.
// ----------------------------------------------------------------------------
package lbce_pkg;

  localparam int LABEL_WORDS     = 16;
  localparam int MAX_LABELS      = 64;
  localparam int WORD_W          = 64;

  localparam int WIDX_W     = $clog2(LABEL_WORDS);
  localparam int LBL_W      = $clog2(MAX_LABELS);
  localparam int TBL_DEPTH  = MAX_LABELS * LABEL_WORDS;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int MAX_POINTS = WORD_W * LABEL_WORDS;
  localparam int WCNT_W     = $clog2(LABEL_WORDS + 1);

  localparam int LABEL_IN_W = 16;
  localparam int PTS_W      = 11;
  localparam int LCNT_W     = 7;
  localparam int PID_W      = 10;
  localparam int WU_W       = PTS_W + 1 - BIT_W;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_OP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_BEGIN   = 2'd1,
    MODE_ADD     = 2'd2,
    MODE_EXTRACT = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                   mode;
    logic [LABEL_IN_W-1:0]   label;
    logic [WIDX_W-1:0]       word_index;
    logic [WORD_W-1:0]       word_data;
  } in_word_t;

  typedef struct packed {
    logic [PID_W-1:0] point;
    logic             found;
    logic             last;
  } result_t;

  typedef struct packed {
    mode_t              op;
    logic               label_ok;
    logic [LBL_W-1:0]   lbl;
    logic [WIDX_W-1:0]  widx;
    logic [WORD_W-1:0]  data;
  } cmd_t;

endpackage

@@ rtl/label_bitset_combine_extract_core.sv @@
// ----------------------------------------------------------------------------
// label_bitset_combine_extract_core
// Per-label point bitset table with union/intersection accumulation and
// ascending enumeration of the set points in one accumulator word.
//
//   Port group      Direction  Handshake
//   start/cmd       in         accepted when start is high and busy is low
//   result          out        result_valid strobe, one cycle, no back-pressure
//   cfg_*           in         written when cfg_we is high, no wait
//
// A load or begin word takes effect as it leaves the queue.
// An add word for an in-range label holds the back end while it leaves the
// queue and then while the table RAM is read once per bitset word; each word
// updates the accumulator in the cycle after its read.
// An extract word selects and masks the accumulator word as it leaves the
// queue, then yields one result per cycle; the next word is popped afterward.
// Busy is high while the two-entry queue is full; results cannot be held off.
// Reset clears the queue, the accumulator, the sticky flag and the configuration
// registers; the table holds undefined data until loaded.
// ----------------------------------------------------------------------------
module label_bitset_combine_extract_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  lbce_pkg::in_word_t             cmd,
  output logic                           busy,
  input  logic                           cfg_we,
  input  logic [lbce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbce_pkg::CFG_W-1:0]     cfg_data,
  output logic                           result_valid,
  output lbce_pkg::result_t              result
);

  logic                        combine_op;
  logic [lbce_pkg::PTS_W-1:0]  point_count;
  logic [lbce_pkg::LCNT_W-1:0] label_count;
  logic                        q_valid;
  lbce_pkg::cmd_t              q_cmd;
  logic                        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_op  <= 1'b0;
      point_count <= '0;
      label_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbce_pkg::CFG_COMBINE_OP:  combine_op  <= cfg_data[0];
        lbce_pkg::CFG_POINT_COUNT: point_count <= cfg_data[lbce_pkg::PTS_W-1:0];
        lbce_pkg::CFG_LABEL_COUNT: label_count <= cfg_data[lbce_pkg::LCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lbce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .busy        (busy),
    .label_count (label_count),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop)
  );

  lbce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .combine_op   (combine_op),
    .point_count  (point_count),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ rtl/lbce_ram.sv @@
// ----------------------------------------------------------------------------
// lbce_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lbce_front.sv @@
// ----------------------------------------------------------------------------
// lbce_front
// Accepts input words, classifies label ranges and queues commands for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module lbce_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  lbce_pkg::in_word_t          cmd,
  output logic                        busy,
  input  logic [lbce_pkg::LCNT_W-1:0] label_count,
  output logic                        q_valid,
  output lbce_pkg::cmd_t              q_cmd,
  input  logic                        pop
);

  lbce_pkg::cmd_t                   entries [lbce_pkg::Q_DEPTH];
  logic [lbce_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [lbce_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [lbce_pkg::Q_CNT_W-1:0]     count;
  logic                             push;
  logic                             table_ok;
  logic                             count_ok;
  lbce_pkg::cmd_t                   classified;

  assign busy    = (count == lbce_pkg::Q_CNT_W'(lbce_pkg::Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  always_comb begin
    table_ok = (cmd.label[lbce_pkg::LABEL_IN_W-1:lbce_pkg::LBL_W] == '0);
    count_ok = (cmd.label < lbce_pkg::LABEL_IN_W'(label_count));
    classified.op   = cmd.mode;
    classified.lbl  = cmd.label[lbce_pkg::LBL_W-1:0];
    classified.widx = cmd.word_index;
    classified.data = cmd.word_data;
    unique case (cmd.mode)
      lbce_pkg::MODE_ADD:  classified.label_ok = table_ok && count_ok;
      lbce_pkg::MODE_LOAD: classified.label_ok = table_ok;
      default:             classified.label_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lbce_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lbce_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + lbce_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - lbce_pkg::Q_CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= lbce_pkg::Q_CNT_W'(lbce_pkg::Q_DEPTH))
    else $error("Command queue count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("Command queue popped while empty.");

endmodule

@@ rtl/lbce_back.sv @@
// ----------------------------------------------------------------------------
// lbce_back
// Executes queued commands: table loads, accumulator initialisation, label
// combines over the label's table words, and set-bit enumeration of one word.
// ----------------------------------------------------------------------------
module lbce_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  lbce_pkg::cmd_t             q_cmd,
  output logic                       pop,
  input  logic                       combine_op,
  input  logic [lbce_pkg::PTS_W-1:0] point_count,
  output logic                       result_valid,
  output lbce_pkg::result_t          result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADD  = 3'b010,
    S_EXT  = 3'b100
  } state_t;

  state_t                              state;
  logic [lbce_pkg::WORD_W-1:0]         acc [lbce_pkg::LABEL_WORDS];
  logic                                bad;
  logic [lbce_pkg::LBL_W-1:0]          add_lbl;
  logic                                add_and;
  logic [lbce_pkg::WCNT_W-1:0]         cnt;
  logic [lbce_pkg::WIDX_W-1:0]         upd_idx;
  logic [lbce_pkg::WORD_W-1:0]         ext_word;
  logic [lbce_pkg::WIDX_W-1:0]         ext_widx;

  logic                                ram_we;
  logic [$clog2(lbce_pkg::TBL_DEPTH)-1:0] ram_waddr;
  logic [$clog2(lbce_pkg::TBL_DEPTH)-1:0] ram_raddr;
  logic [lbce_pkg::WORD_W-1:0]         ram_rdata;

  logic [lbce_pkg::PTS_W-1:0]          pts_sat;
  logic [lbce_pkg::PTS_W:0]            pts_sum;
  logic [lbce_pkg::WU_W-1:0]           words_used;
  logic [lbce_pkg::BIT_W-1:0]          rem;
  logic [lbce_pkg::WORD_W-1:0]         tail_mask;
  logic [lbce_pkg::WORD_W-1:0]         sel_word;
  logic [lbce_pkg::WORD_W-1:0]         ext_load;
  logic                                in_use;
  logic                                is_tail;

  logic [lbce_pkg::WORD_W-1:0]         low;
  logic [lbce_pkg::WORD_W-1:0]         rest;
  logic [lbce_pkg::BIT_W-1:0]          pos;

  assign pop       = (state == S_IDLE) && q_valid;
  assign ram_we    = pop && (q_cmd.op == lbce_pkg::MODE_LOAD) && q_cmd.label_ok;
  assign ram_waddr = {q_cmd.lbl, q_cmd.widx};
  assign ram_raddr = {add_lbl, cnt[lbce_pkg::WIDX_W-1:0]};
  assign upd_idx   = lbce_pkg::WIDX_W'(cnt - lbce_pkg::WCNT_W'(1));

  lbce_ram #(
    .WIDTH (lbce_pkg::WORD_W),
    .DEPTH (lbce_pkg::TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_cmd.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    pts_sat = (point_count > lbce_pkg::PTS_W'(lbce_pkg::MAX_POINTS)) ?
              lbce_pkg::PTS_W'(lbce_pkg::MAX_POINTS) : point_count;
    pts_sum = {1'b0, pts_sat} + (lbce_pkg::PTS_W + 1)'(lbce_pkg::WORD_W - 1);
    words_used = pts_sum[lbce_pkg::PTS_W:lbce_pkg::BIT_W];
    rem = pts_sat[lbce_pkg::BIT_W-1:0];
    tail_mask = (rem == '0) ? '1 :
                ((lbce_pkg::WORD_W'(1) << rem) - lbce_pkg::WORD_W'(1));
    in_use  = !bad && (lbce_pkg::WU_W'(q_cmd.widx) < words_used);
    is_tail = (lbce_pkg::WU_W'(q_cmd.widx) == words_used - lbce_pkg::WU_W'(1));
    sel_word = acc[q_cmd.widx];
    if (!in_use) begin
      ext_load = '0;
    end else if (is_tail) begin
      ext_load = sel_word & tail_mask;
    end else begin
      ext_load = sel_word;
    end
  end

  always_comb begin
    low  = ext_word & (~ext_word + lbce_pkg::WORD_W'(1));
    rest = ext_word & ~low;
    pos  = '0;
    for (int i = 0; i < lbce_pkg::WORD_W; i++) begin
      if (low[i]) begin
        pos = pos | lbce_pkg::BIT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bad          <= 1'b0;
      result_valid <= 1'b0;
      cnt          <= '0;
      for (int w = 0; w < lbce_pkg::LABEL_WORDS; w++) begin
        acc[w] <= '0;
      end
    end else begin
      result_valid <= (state == S_EXT);
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (q_cmd.op)
              lbce_pkg::MODE_LOAD: begin
              end
              lbce_pkg::MODE_BEGIN: begin
                for (int w = 0; w < lbce_pkg::LABEL_WORDS; w++) begin
                  acc[w] <= combine_op ? '1 : '0;
                end
                bad <= 1'b0;
              end
              lbce_pkg::MODE_ADD: begin
                if (q_cmd.label_ok) begin
                  add_lbl <= q_cmd.lbl;
                  add_and <= combine_op;
                  cnt     <= '0;
                  state   <= S_ADD;
                end else if (combine_op) begin
                  bad <= 1'b1;
                end
              end
              lbce_pkg::MODE_EXTRACT: begin
                ext_word <= ext_load;
                ext_widx <= q_cmd.widx;
                state    <= S_EXT;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          if (cnt != '0) begin
            acc[upd_idx] <= add_and ? (acc[upd_idx] & ram_rdata) :
                                      (acc[upd_idx] | ram_rdata);
          end
          cnt <= cnt + lbce_pkg::WCNT_W'(1);
          if (cnt == lbce_pkg::WCNT_W'(lbce_pkg::LABEL_WORDS)) begin
            state <= S_IDLE;
          end
        end
        S_EXT: begin
          if (ext_word == '0) begin
            result.point <= '0;
            result.found <= 1'b0;
            result.last  <= 1'b1;
            state        <= S_IDLE;
          end else begin
            result.point <= {ext_widx, pos};
            result.found <= 1'b1;
            result.last  <= (rest == '0);
            ext_word     <= rest;
            if (rest == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_EXT))
    else $error("Result strobe outside word enumeration.");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (state == S_IDLE))
    else $error("Enumeration continued after its final result.");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> result.last)
    else $error("Empty-word result not marked as final.");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for label_bitset_combine_extract_core. Command words go
// in through the start/busy handshake, and a scoreboard class mirrors the label
// table, the accumulator and the sticky out-of-range flag to predict every
// enumerated point. A short directed part covers the corner cases. Randomized
// query sequences then run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbce_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned ITEMS_PER_PHASE = 32;

  class bitset_scoreboard;
    logic [WORD_W-1:0] bitsets [TBL_DEPTH];
    bit                loaded  [TBL_DEPTH];
    logic [WORD_W-1:0] acc     [LABEL_WORDS];
    bit                bad_flag;
    bit                op_and;
    int unsigned       n_points;
    int unsigned       n_labels;
    result_t           points_due [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      foreach (acc[i]) acc[i] = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      bad_flag = 1'b0;
      op_and   = 1'b0;
      n_points = 0;
      n_labels = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function int unsigned outstanding();
      return points_due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        CFG_COMBINE_OP:  op_and = val[0];
        CFG_POINT_COUNT: n_points = val[PTS_W-1:0];
        CFG_LABEL_COUNT: n_labels = val[LCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(in_word_t w);
      int unsigned       base;
      int unsigned       pts;
      int unsigned       used;
      int unsigned       total;
      int unsigned       n;
      int                i;
      int                b;
      logic [WORD_W-1:0] word;
      result_t           r;
      base = w.label * LABEL_WORDS;
      case (w.mode)
        MODE_LOAD: begin
          if (w.label < MAX_LABELS) begin
            bitsets[base + w.word_index] = w.word_data;
            loaded[base + w.word_index]  = 1'b1;
          end
        end
        MODE_BEGIN: begin
          foreach (acc[k]) acc[k] = {WORD_W{op_and}};
          bad_flag = 1'b0;
        end
        MODE_ADD: begin
          if (w.label < n_labels && w.label < MAX_LABELS) begin
            for (i = 0; i < LABEL_WORDS; i++) begin
              acc[i] = op_and ? (acc[i] & bitsets[base + i]) : (acc[i] | bitsets[base + i]);
            end
          end else if (op_and) begin
            bad_flag = 1'b1;
          end
        end
        default: begin
          pts  = (n_points > MAX_POINTS) ? MAX_POINTS : n_points;
          used = (pts + WORD_W - 1) / WORD_W;
          word = '0;
          if (!bad_flag && w.word_index < used) begin
            word = acc[w.word_index];
            if (w.word_index == used - 1 && pts % WORD_W != 0) begin
              word &= (64'd1 << (pts % WORD_W)) - 64'd1;
            end
          end
          total = $countones(word);
          if (total == 0) begin
            r.point = '0;
            r.found = 1'b0;
            r.last  = 1'b1;
            points_due = {points_due, r};
          end else begin
            n = 0;
            for (b = 0; b < WORD_W; b++) begin
              if (word[b]) begin
                n++;
                r.point = PID_W'(w.word_index * WORD_W + b);
                r.found = 1'b1;
                r.last  = (n == total);
                points_due = {points_due, r};
              end
            end
          end
        end
      endcase
    endfunction

    function void check_point(result_t r);
      result_t e;
      if (points_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result point=%0d found=%0b last=%0b",
                 $time, r.point, r.found, r.last);
        return;
      end
      e = points_due.pop_front();
      checked++;
      if (r !== e) begin
        errors++;
        if (r.point !== e.point)
          $display("%0t: point expected %0d actual %0d", $time, e.point, r.point);
        if (r.found !== e.found)
          $display("%0t: found expected %0b actual %0b", $time, e.found, r.found);
        if (r.last !== e.last)
          $display("%0t: last expected %0b actual %0b", $time, e.last, r.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start;
  in_word_t             cmd;
  logic                 busy;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 result_valid;
  result_t              result;

  bitset_scoreboard sb = new();
  int unsigned      idle_pct = 0;
  int unsigned      items_sent = 0;
  int unsigned      settings_run = 0;
  int unsigned      cycle_count = 0;

  label_bitset_combine_extract_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sb.check_point(result);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, sb.outstanding());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] random_bits();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return {$urandom, $urandom} & {$urandom, $urandom};
      3: return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_label();
    int unsigned span;
    span = (sb.n_labels > MAX_LABELS) ? MAX_LABELS : sb.n_labels;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, MAX_LABELS - 1);
      default: return (span == 0) ? $urandom_range(0, 3) : $urandom_range(0, span - 1);
    endcase
  endfunction

  function automatic int unsigned pick_word();
    int unsigned pts;
    int unsigned used;
    pts  = (sb.n_points > MAX_POINTS) ? MAX_POINTS : sb.n_points;
    used = (pts + WORD_W - 1) / WORD_W;
    if (used == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, LABEL_WORDS - 1);
    if ($urandom_range(0, 3) == 0) return used - 1;
    return $urandom_range(0, used - 1);
  endfunction

  task automatic send(input mode_t m, input int unsigned lbl, input int unsigned widx,
                      input logic [WORD_W-1:0] data);
    in_word_t w;
    w.mode       = m;
    w.label      = lbl[LABEL_IN_W-1:0];
    w.word_index = widx[WIDX_W-1:0];
    w.word_data  = data;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    items_sent++;
  endtask

  task automatic add_label(input int unsigned lbl);
    int unsigned i;
    if (lbl < MAX_LABELS) begin
      for (i = 0; i < LABEL_WORDS; i++) begin
        if (!sb.loaded[lbl * LABEL_WORDS + i]) send(MODE_LOAD, lbl, i, random_bits());
      end
    end
    send(MODE_ADD, lbl, $urandom_range(0, 15), {$urandom, $urandom});
  endtask

  task automatic extract(input int unsigned widx);
    send(MODE_EXTRACT, $urandom_range(0, 65535), widx, {$urandom, $urandom});
  endtask

  task automatic begin_query();
    send(MODE_BEGIN, $urandom_range(0, 65535), $urandom_range(0, 15), {$urandom, $urandom});
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit op, input int unsigned pts, input int unsigned lbls);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMBINE_OP;
    cfg_data  <= CFG_W'(op);
    @(posedge clk);
    cfg_index <= CFG_POINT_COUNT;
    cfg_data  <= CFG_W'(pts);
    @(posedge clk);
    cfg_index <= CFG_LABEL_COUNT;
    cfg_data  <= CFG_W'(lbls);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_COMBINE_OP, op);
    sb.set_reg(CFG_POINT_COUNT, pts);
    sb.set_reg(CFG_LABEL_COUNT, lbls);
    settings_run++;
  endtask

  task automatic run_phase(input bit op, input int unsigned pts, input int unsigned lbls,
                           input int unsigned idle);
    int unsigned first;
    configure(op, pts, lbls);
    idle_pct = idle;
    first    = items_sent;
    while (items_sent - first < ITEMS_PER_PHASE) begin
      if ($urandom_range(0, 9) < 2) begin
        case (mode_t'($urandom_range(0, 3)))
          MODE_LOAD:  send(MODE_LOAD, $urandom_range(0, 1) ? $urandom_range(0, MAX_LABELS - 1)
                                                            : $urandom_range(0, 65535),
                           $urandom_range(0, 15), random_bits());
          MODE_BEGIN: begin_query();
          MODE_ADD:   add_label($urandom_range(0, 65535));
          default:    extract($urandom_range(0, 15));
        endcase
      end else begin
        if ($urandom_range(0, 7) != 0) begin_query();
        repeat ($urandom_range(0, 4)) add_label(pick_label());
        repeat ($urandom_range(1, 3)) extract(pick_word());
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    start     <= 1'b0;
    cmd       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_COMBINE_OP;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(1'b0, 1024, 64);
    extract(0);
    extract(15);
    send(MODE_LOAD, 16'hFFFF, 15, '1);
    send(MODE_LOAD, MAX_LABELS, 0, '1);
    begin_query();
    extract(3);
    add_label(0);
    add_label(16'hFFFF);
    add_label(63);
    extract(0);
    extract(15);

    configure(1'b1, 1024, 64);
    add_label(63);
    extract(15);
    begin_query();
    extract(0);
    extract(15);
    add_label(MAX_LABELS);
    extract(0);

    configure(1'b1, 2047, 1);
    begin_query();
    extract(15);
    add_label(1);
    extract(15);

    configure(1'b1, 65, 127);
    begin_query();
    extract(1);
    extract(2);
    add_label(63);
    extract(0);
    add_label(100);
    extract(1);

    configure(1'b0, 0, 0);
    extract(0);
    begin_query();
    add_label(0);
    extract(0);

    run_phase(1'b1, 1024, 64, 71);
    run_phase(1'b0, 1000, 16, 22);
    run_phase(1'b1, 130, 127, 0);
    run_phase(1'b1, 2047, 8, 71);
    run_phase(1'b0, 63, 64, 22);
    run_phase(1'b0, 1, 1, 0);
    run_phase(1'b1, 65, 32, 22);

    settle();
    $display("Accepted %0d input words under %0d register settings; checked %0d points.",
             items_sent, settings_run, sb.checked);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
